[rtl/core/frt_pkg.sv]
// Shared types, constants and status codes of the fragment reassembly tracker.
package frt_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int MAX_FRAGMENTS_DEF = 64;
  localparam int MAX_MESSAGE_BYTES_DEF = 65536;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_BAD_GEOM  = 3'd4,
    ST_NO_SLOT   = 3'd5
  } status_t;

  // One classified header as it travels from the front to the back part.
  typedef struct packed {
    logic [63:0] sender;
    logic [31:0] sequence_req;
    logic [16:0] total_bytes;
    logic [16:0] frag_offset;
    logic [5:0]  frag_bit;
    logic [6:0]  frag_total;
    logic        reject;
    status_t     rej_status;
    logic        wen;
  } cmd_t;

endpackage

[rtl/core/fragment_reassembly_tracker_unit.sv]
// Top level of the fragment reassembly tracker.
// Rejected headers go straight to the result beat; others scan the slots for a
// match, failing that for a victim. One header at a time; busy drops with the
// result beat, so the next header can be taken at the edge that ends it.
// Reset (rst, synchronous) clears all slots and the activity counter.
// Results are strobed by done for one cycle; the receiver cannot stall.
module fragment_reassembly_tracker_unit #(
  parameter int NUM_SLOTS = frt_pkg::NUM_SLOTS_DEF,
  parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
  parameter int MAX_MESSAGE_BYTES = frt_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] sender,
  input  logic [31:0] sequence_req,
  input  logic [31:0] message_size,
  input  logic [31:0] frag_byte_offset,
  input  logic [15:0] fragment_number,
  input  logic [15:0] fragment_total,
  input  logic [15:0] payload_bytes,
  input  logic [8:0]  name_bytes,
  output logic        done,
  output logic [2:0]  status,
  output logic [1:0]  slot,
  output logic        write_enable,
  output logic [16:0] write_offset,
  output logic        complete,
  output logic [16:0] delivered_size
);

  logic          cmd_valid;
  logic          cmd_ready;
  frt_pkg::cmd_t cmd;

  frt_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS),
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk, .rst, .start, .busy, .sender, .sequence_req, .message_size,
    .frag_byte_offset, .fragment_number, .fragment_total, .payload_bytes,
    .name_bytes, .cmd_valid, .cmd, .cmd_ready
  );

  frt_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_ready, .done, .status, .slot,
    .write_enable, .write_offset, .complete, .delivered_size
  );

  // A result beat always follows the release of the queued command.
  a_done_after_release: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> done) else $error("result beat missing");

  // Completion implies a new fragment.
  a_complete_new: assert property (@(posedge clk) disable iff (rst)
    done && complete |-> status == frt_pkg::ST_NEW) else $error("complete without new");

  // No result without a command in flight.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd_valid)) else $error("spurious result beat");

endmodule

[rtl/core/frt_front.sv]
// Front part: header checks and classification into a command beat.
module frt_front #(
  parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
  parameter int MAX_MESSAGE_BYTES = frt_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [63:0]   sender,
  input  logic [31:0]   sequence_req,
  input  logic [31:0]   message_size,
  input  logic [31:0]   frag_byte_offset,
  input  logic [15:0]   fragment_number,
  input  logic [15:0]   fragment_total,
  input  logic [15:0]   payload_bytes,
  input  logic [8:0]    name_bytes,
  output logic          cmd_valid,
  output frt_pkg::cmd_t cmd,
  input  logic          cmd_ready
);

  localparam logic [32:0] MaxBytes = 33'(MAX_MESSAGE_BYTES);
  localparam logic [15:0] MaxFrags = 16'(MAX_FRAGMENTS);

  logic          too_large;
  logic          too_many;
  logic          bad_geom;
  logic [32:0]   end_byte;
  logic          wen;
  frt_pkg::cmd_t cmd_next;

  // Checks in priority order: size, count, geometry.
  always_comb begin
    end_byte  = {1'b0, frag_byte_offset} + 33'(payload_bytes);
    too_large = {1'b0, message_size} > MaxBytes;
    too_many  = fragment_total > MaxFrags;
    bad_geom  = (fragment_number >= fragment_total) || (end_byte > {1'b0, message_size});
    if (fragment_number == 16'd0) begin
      wen = 16'(name_bytes) < payload_bytes;
    end else begin
      wen = payload_bytes != 16'd0;
    end
    cmd_next.sender       = sender;
    cmd_next.sequence_req = sequence_req;
    cmd_next.total_bytes  = message_size[16:0];
    cmd_next.frag_offset  = frag_byte_offset[16:0];
    cmd_next.frag_bit     = fragment_number[5:0];
    cmd_next.frag_total   = fragment_total[6:0];
    cmd_next.wen          = wen;
    cmd_next.reject       = too_large || too_many || bad_geom;
    if (too_large) begin
      cmd_next.rej_status = frt_pkg::ST_TOO_LARGE;
    end else if (too_many) begin
      cmd_next.rej_status = frt_pkg::ST_TOO_MANY;
    end else begin
      cmd_next.rej_status = frt_pkg::ST_BAD_GEOM;
    end
  end

  // Single-entry queue between the two parts.
  assign busy = cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (start && !busy) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= cmd_next;
    end
  end

endmodule

[rtl/core/frt_back.sv]
// Back part: slot lookup, victim scan and slot update, one slot per cycle.
module frt_back #(
  parameter int NUM_SLOTS = frt_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  frt_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          done,
  output logic [2:0]    status,
  output logic [1:0]    slot,
  output logic          write_enable,
  output logic [16:0]   write_offset,
  output logic          complete,
  output logic [16:0]   delivered_size
);

  localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_VICTIM, S_UPDATE, S_REJECT, S_NOSLOT
  } state_t;

  state_t           state;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  sel;
  logic             found;
  logic             claim;
  logic             have_age;
  logic [31:0]      max_age;
  logic [31:0]      counter;

  logic             v_valid  [NUM_SLOTS];
  logic [63:0]      v_sender [NUM_SLOTS];
  logic [31:0]      v_seq    [NUM_SLOTS];
  logic [6:0]       v_rem    [NUM_SLOTS];
  logic [31:0]      v_stamp  [NUM_SLOTS];
  logic [63:0]      v_bits   [NUM_SLOTS];

  logic [31:0]      age;
  logic [63:0]      clr_mask;
  logic [63:0]      fbit;
  logic [63:0]      bits_cur;
  logic [6:0]       rem_cur;

  // Signed age of the slot under the scan pointer and update helpers.
  always_comb begin
    age      = counter - v_stamp[idx];
    fbit     = 64'd1 << cmd.frag_bit;
    clr_mask = (cmd.frag_total >= 7'd64) ? 64'd0 : ~((64'd1 << cmd.frag_total[5:0]) - 64'd1);
    bits_cur = claim ? (v_bits[sel] & clr_mask) : v_bits[sel];
    rem_cur  = claim ? cmd.frag_total : v_rem[sel];
  end

  assign cmd_ready = (state == S_UPDATE) || (state == S_REJECT) || (state == S_NOSLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      counter <= 32'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        v_valid[i]  <= 1'b0;
        v_sender[i] <= 64'd0;
        v_seq[i]    <= 32'd0;
        v_rem[i]    <= 7'd0;
        v_stamp[i]  <= 32'd0;
        v_bits[i]   <= 64'd0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          idx   <= '0;
          found <= 1'b0;
          claim <= 1'b0;
          if (cmd_valid) begin
            state <= cmd.reject ? S_REJECT : S_MATCH;
          end
        end
        // Look for a slot that already holds this sender and sequence.
        S_MATCH: begin
          if (v_valid[idx] && v_sender[idx] == cmd.sender && v_seq[idx] == cmd.sequence_req) begin
            sel   <= idx;
            state <= S_UPDATE;
          end else if (idx == LastIdx) begin
            idx      <= '0;
            have_age <= 1'b0;
            max_age  <= 32'd0;
            state    <= S_VICTIM;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // First idle slot, else the oldest one by signed age.
        S_VICTIM: begin
          if (v_rem[idx] == 7'd0) begin
            sel   <= idx;
            found <= 1'b1;
            claim <= 1'b1;
            state <= S_UPDATE;
          end else begin
            if (!age[31] && (!have_age || age > max_age)) begin
              sel      <= idx;
              found    <= 1'b1;
              have_age <= 1'b1;
              max_age  <= age;
            end else if (age == 32'hFFFF_FFFF && !have_age && !found) begin
              // An age of minus one is negative and is not taken.
              found <= found;
            end
            if (idx == LastIdx) begin
              if (found || (!age[31] && (!have_age || age > max_age))) begin
                claim <= 1'b1;
                state <= S_UPDATE;
              end else begin
                state <= S_NOSLOT;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        // Write back the slot and emit the result beat.
        S_UPDATE: begin
          v_valid[sel]  <= 1'b1;
          v_sender[sel] <= cmd.sender;
          v_seq[sel]    <= cmd.sequence_req;
          v_stamp[sel]  <= counter;
          counter       <= counter + 32'd1;
          slot          <= 2'(sel);
          write_enable  <= cmd.wen;
          write_offset  <= cmd.wen ? cmd.frag_offset : 17'd0;
          done          <= 1'b1;
          if ((bits_cur & fbit) != 64'd0) begin
            v_bits[sel]    <= bits_cur;
            v_rem[sel]     <= rem_cur;
            status         <= frt_pkg::ST_DUPLICATE;
            complete       <= 1'b0;
            delivered_size <= 17'd0;
          end else begin
            v_bits[sel]    <= bits_cur | fbit;
            status         <= frt_pkg::ST_NEW;
            if (rem_cur != 7'd0) begin
              v_rem[sel]     <= rem_cur - 7'd1;
              complete       <= rem_cur == 7'd1;
              delivered_size <= (rem_cur == 7'd1) ? cmd.total_bytes : 17'd0;
            end else begin
              v_rem[sel]     <= rem_cur;
              complete       <= 1'b0;
              delivered_size <= 17'd0;
            end
          end
          state <= S_IDLE;
        end
        S_REJECT: begin
          status         <= cmd.rej_status;
          slot           <= 2'd0;
          write_enable   <= 1'b0;
          write_offset   <= 17'd0;
          complete       <= 1'b0;
          delivered_size <= 17'd0;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        // Every slot is busy and none is old enough to take over.
        S_NOSLOT: begin
          status         <= frt_pkg::ST_NO_SLOT;
          slot           <= 2'd0;
          write_enable   <= 1'b0;
          write_offset   <= 17'd0;
          complete       <= 1'b0;
          delivered_size <= 17'd0;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
